[src/mtnc_pkg.sv]
package mtnc_pkg;

   // Characters that steer the tag scanner
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // Error codes, first one found is kept
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_UNCLOSED = 3'd1;
   localparam logic [2:0] ERR_EMPTY    = 3'd2;
   localparam logic [2:0] ERR_MISMATCH = 3'd3;
   localparam logic [2:0] ERR_OPEN     = 3'd4;
   localparam logic [2:0] ERR_LONG     = 3'd5;
   localparam logic [2:0] ERR_OVERFLOW = 3'd6;

   // Document verdict handed from the parser to the output register
   typedef struct packed {
      logic       done;
      logic       doc_ok;
      logic [2:0] err;
   } mtnc_result_type;

   // Sticky error: only the first error is recorded
   function automatic logic [2:0] mtnc_raise(input logic [2:0] cur, input logic [2:0] kind);
      mtnc_raise = (cur == ERR_NONE) ? kind : cur;
   endfunction

endpackage

[src/mtnc_stack_mem.sv]
module mtnc_stack_mem
   import mtnc_pkg::*;
#(
   parameter int STACK_DEPTH    = 64,
   parameter int MAX_NAME_BYTES = 16,
   localparam int CNT_W  = $clog2(MAX_NAME_BYTES + 1),
   localparam int IDX_W  = $clog2(STACK_DEPTH),
   localparam int ADDR_W = $clog2(STACK_DEPTH * MAX_NAME_BYTES)
) (
   input  logic              clock,
   input  logic              byte_we,
   input  logic [ADDR_W-1:0] byte_waddr,
   input  logic [7:0]        byte_wdata,
   input  logic [ADDR_W-1:0] byte_raddr,
   output logic [7:0]        byte_rdata,
   input  logic              len_we,
   input  logic [IDX_W-1:0]  len_waddr,
   input  logic [CNT_W-1:0]  len_wdata,
   input  logic [IDX_W-1:0]  len_raddr,
   output logic [CNT_W-1:0]  len_rdata
);

   localparam int BYTE_ENTRIES = STACK_DEPTH * MAX_NAME_BYTES;

   logic [7:0]       name_mem [BYTE_ENTRIES];
   logic [CNT_W-1:0] len_mem  [STACK_DEPTH];
   logic [7:0]       byte_rd_ff;
   logic [CNT_W-1:0] len_rd_ff;

   // Name bytes: one write, one registered read, write data forwarded on a hit
   always_ff @(posedge clock) begin
      if (byte_we) begin
         name_mem[byte_waddr] <= byte_wdata;
      end
      if (byte_we && (byte_waddr == byte_raddr)) begin
         byte_rd_ff <= byte_wdata;
      end else begin
         byte_rd_ff <= name_mem[byte_raddr];
      end
   end

   // Name lengths: a push writes the entry that the next prefetch reads
   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[len_waddr] <= len_wdata;
      end
      if (len_we && (len_waddr == len_raddr)) begin
         len_rd_ff <= len_wdata;
      end else begin
         len_rd_ff <= len_mem[len_raddr];
      end
   end

   assign byte_rdata = byte_rd_ff;
   assign len_rdata  = len_rd_ff;

endmodule

[src/mtnc_parser.sv]
module mtnc_parser
   import mtnc_pkg::*;
#(
   parameter int STACK_DEPTH    = 64,
   parameter int MAX_NAME_BYTES = 16,
   localparam int CNT_W  = $clog2(MAX_NAME_BYTES + 1),
   localparam int SP_W   = $clog2(STACK_DEPTH + 1),
   localparam int IDX_W  = $clog2(STACK_DEPTH),
   localparam int ADDR_W = $clog2(STACK_DEPTH * MAX_NAME_BYTES)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [7:0]        text_byte,
   input  logic              end_of_doc,
   output logic              byte_we,
   output logic [ADDR_W-1:0] byte_waddr,
   output logic [7:0]        byte_wdata,
   output logic [ADDR_W-1:0] byte_raddr,
   input  logic [7:0]        byte_rdata,
   output logic              len_we,
   output logic [IDX_W-1:0]  len_waddr,
   output logic [CNT_W-1:0]  len_wdata,
   output logic [IDX_W-1:0]  len_raddr,
   input  logic [CNT_W-1:0]  len_rdata,
   output mtnc_result_type   result
);

   localparam int AW1 = ADDR_W + 1;

   localparam logic [1:0] MODE_OUT   = 2'd0;
   localparam logic [1:0] MODE_START = 2'd1;
   localparam logic [1:0] MODE_NAME  = 2'd2;
   localparam logic [1:0] MODE_REST  = 2'd3;

   logic [1:0]       mode_ff, mode_in;
   logic             closing_ff, closing_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             slash_ff, slash_in;
   logic [SP_W-1:0]  sp_ff, sp_in;
   logic [2:0]       sticky_ff, sticky_in;
   logic             mism_ff, mism_in;

   logic is_lt, is_gt, is_slash, is_space;
   logic in_name, open_slash, do_open, do_finish, do_name, do_rest;
   logic cnt_full, sp_full, sp_empty;
   logic [IDX_W-1:0] top_in;

   // Byte classes
   assign is_lt    = (text_byte == CH_LT);
   assign is_gt    = (text_byte == CH_GT);
   assign is_slash = (text_byte == CH_SLASH);
   assign is_space = (text_byte == CH_SPACE);

   // What this byte does to the tag scanner
   assign in_name    = (mode_ff == MODE_START) || (mode_ff == MODE_NAME);
   assign open_slash = (mode_ff == MODE_START) && !closing_ff && is_slash;
   assign do_open    = (mode_ff == MODE_OUT) && is_lt;
   assign do_finish  = ((in_name && !open_slash) || (mode_ff == MODE_REST)) && is_gt;
   assign do_name    = in_name && !open_slash && !is_gt && !is_space && !is_slash;
   assign do_rest    = in_name && !open_slash && !is_gt && (is_space || is_slash);

   assign cnt_full = (cnt_ff == CNT_W'(MAX_NAME_BYTES));
   assign sp_full  = (sp_ff == SP_W'(STACK_DEPTH));
   assign sp_empty = (sp_ff == '0);

   // Write side always points at the free row above the top
   assign byte_waddr = ADDR_W'(AW1'(sp_ff) * AW1'(MAX_NAME_BYTES) + AW1'(cnt_ff));
   assign byte_wdata = text_byte;
   assign len_waddr  = IDX_W'(sp_ff);
   assign len_wdata  = cnt_ff;

   // Prefetch the top entry at the next state's position
   assign top_in     = IDX_W'(sp_in - SP_W'(1));
   assign byte_raddr = ADDR_W'(AW1'(top_in) * AW1'(MAX_NAME_BYTES) + AW1'(cnt_in));
   assign len_raddr  = top_in;

   // Next state
   always_comb begin
      mode_in    = mode_ff;
      closing_in = closing_ff;
      cnt_in     = cnt_ff;
      slash_in   = slash_ff;
      sp_in      = sp_ff;
      sticky_in  = sticky_ff;
      mism_in    = mism_ff;
      byte_we    = 1'b0;
      len_we     = 1'b0;
      result     = '0;
      if (take) begin
         slash_in = is_slash;
         if (do_open) begin
            mode_in    = MODE_START;
            closing_in = 1'b0;
            cnt_in     = '0;
            mism_in    = 1'b0;
         end
         if (open_slash) begin
            closing_in = 1'b1;
         end
         if (do_rest) begin
            mode_in = MODE_REST;
         end
         // Name byte: store it or compare against the top entry
         if (do_name) begin
            mode_in = MODE_NAME;
            if (cnt_full) begin
               sticky_in = mtnc_raise(sticky_in, ERR_LONG);
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
               if (!closing_ff) begin
                  byte_we = !sp_full;
               end else if (sp_empty || (cnt_ff >= len_rdata) || (byte_rdata != text_byte)) begin
                  mism_in = 1'b1;
               end
            end
         end
         // End of tag: push, pop or skip
         if (do_finish) begin
            mode_in = MODE_OUT;
            if (cnt_ff == '0) begin
               sticky_in = mtnc_raise(sticky_in, ERR_EMPTY);
            end else if (slash_ff) begin
               sticky_in = sticky_ff;
            end else if (!closing_ff) begin
               if (sp_full) begin
                  sticky_in = mtnc_raise(sticky_in, ERR_OVERFLOW);
               end else begin
                  len_we = 1'b1;
                  sp_in  = sp_ff + SP_W'(1);
               end
            end else if (sp_empty || mism_ff || (cnt_ff != len_rdata)) begin
               sticky_in = mtnc_raise(sticky_in, ERR_MISMATCH);
            end else begin
               sp_in = sp_ff - SP_W'(1);
            end
         end
         // Last byte: final checks, verdict, back to the start state
         if (end_of_doc) begin
            if (mode_in != MODE_OUT) begin
               sticky_in = mtnc_raise(sticky_in, ERR_UNCLOSED);
            end
            if (sp_in != '0) begin
               sticky_in = mtnc_raise(sticky_in, ERR_OPEN);
            end
            result.done   = 1'b1;
            result.doc_ok = (sticky_in == ERR_NONE);
            result.err    = sticky_in;
            mode_in    = MODE_OUT;
            closing_in = 1'b0;
            cnt_in     = '0;
            slash_in   = 1'b0;
            sp_in      = '0;
            sticky_in  = ERR_NONE;
            mism_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_OUT;
         closing_ff <= 1'b0;
         cnt_ff     <= '0;
         slash_ff   <= 1'b0;
         sp_ff      <= '0;
         sticky_ff  <= ERR_NONE;
         mism_ff    <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         closing_ff <= closing_in;
         cnt_ff     <= cnt_in;
         slash_ff   <= slash_in;
         sp_ff      <= sp_in;
         sticky_ff  <= sticky_in;
         mism_ff    <= mism_in;
      end
   end

endmodule

[src/markup_tag_nesting_checker.sv]
// Channel | Direction | Handshake             | Payload
// req     | in        | req_valid / req_ready | req_text_byte[7:0], req_end_of_document
// rsp     | out       | rsp_valid / rsp_ready | rsp_document_valid, rsp_error_kind[2:0]
//
// One byte per cycle while req_ready is high; the stack memories give registered reads addressed
// at the next state's top entry, so each byte needs a single read of each memory.
// The verdict appears in the cycle after the last byte and sits in an output register.
// Reset clears the scanner and the stack pointer; the stack memories are not cleared,
// an entry is only read after a push has written it. No clearing pass.
// req_ready drops only while a verdict waits and rsp_ready is low.
module markup_tag_nesting_checker
   import mtnc_pkg::*;
#(
   parameter int STACK_DEPTH    = 64,
   parameter int MAX_NAME_BYTES = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_text_byte,
   input  logic       req_end_of_document,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_document_valid,
   output logic [2:0] rsp_error_kind
);

   localparam int CNT_W  = $clog2(MAX_NAME_BYTES + 1);
   localparam int IDX_W  = $clog2(STACK_DEPTH);
   localparam int ADDR_W = $clog2(STACK_DEPTH * MAX_NAME_BYTES);

   logic              take;
   logic              byte_we;
   logic [ADDR_W-1:0] byte_waddr, byte_raddr;
   logic [7:0]        byte_wdata, byte_rdata;
   logic              len_we;
   logic [IDX_W-1:0]  len_waddr, len_raddr;
   logic [CNT_W-1:0]  len_wdata, len_rdata;
   mtnc_result_type   result;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_ok_ff;
   logic [2:0] rsp_err_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;

   mtnc_parser #(
      .STACK_DEPTH    (STACK_DEPTH),
      .MAX_NAME_BYTES (MAX_NAME_BYTES)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .text_byte  (req_text_byte),
      .end_of_doc (req_end_of_document),
      .byte_we    (byte_we),
      .byte_waddr (byte_waddr),
      .byte_wdata (byte_wdata),
      .byte_raddr (byte_raddr),
      .byte_rdata (byte_rdata),
      .len_we     (len_we),
      .len_waddr  (len_waddr),
      .len_wdata  (len_wdata),
      .len_raddr  (len_raddr),
      .len_rdata  (len_rdata),
      .result     (result)
   );

   mtnc_stack_mem #(
      .STACK_DEPTH    (STACK_DEPTH),
      .MAX_NAME_BYTES (MAX_NAME_BYTES)
   ) u_stack (
      .clock      (clock),
      .byte_we    (byte_we),
      .byte_waddr (byte_waddr),
      .byte_wdata (byte_wdata),
      .byte_raddr (byte_raddr),
      .byte_rdata (byte_rdata),
      .len_we     (len_we),
      .len_waddr  (len_waddr),
      .len_wdata  (len_wdata),
      .len_raddr  (len_raddr),
      .len_rdata  (len_rdata)
   );

   // Output register: loads a verdict, clears once the verdict is taken
   assign rsp_valid_in = result.done || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.done) begin
         rsp_ok_ff  <= result.doc_ok;
         rsp_err_ff <= result.err;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_document_valid = rsp_ok_ff;
   assign rsp_error_kind     = rsp_err_ff;

endmodule

[src/mtnc_checker.sv]
module mtnc_checker
   import mtnc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_end_of_document,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_document_valid,
   input logic [2:0] rsp_error_kind
);

   // Verdict flag agrees with the error code
   a_ok_matches_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_document_valid == (rsp_error_kind == ERR_NONE)))
      else $error("document_valid disagrees with error_kind");

   // Last byte produces a verdict in the next cycle
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_end_of_document) |=> rsp_valid)
      else $error("no verdict after last byte");

   // Other bytes produce nothing
   a_mid_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_end_of_document) |=> !rsp_valid)
      else $error("verdict without last byte");

   // A stalled verdict holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_document_valid) && $stable(rsp_error_kind)))
      else $error("stalled verdict changed");

endmodule

bind markup_tag_nesting_checker mtnc_checker u_mtnc_checker (.*);

[bench/markup_tag_nesting_checker_tb.sv]
`timescale 1ns / 100ps

module markup_tag_nesting_checker_tb;
   import mtnc_pkg::*;

   localparam int STACK_DEPTH    = 64;
   localparam int MAX_NAME_BYTES = 16;
   localparam int NAME_CAP       = 20;    // longest name the generator builds
   localparam int RANDOM_BYTES   = 940;
   localparam int RANDOM_DOCS    = 9;
   localparam int DEEP_DOC_INDEX = 8;
   localparam int HOLD_START     = 5;     // verdicts seen before the long receiver hold
   localparam int HOLD_CYCLES    = 150;
   localparam int STALL_LIMIT    = 2000;
   localparam int TAIL_CYCLES    = 16;
   localparam int REPORT_LIMIT   = 10;

   typedef enum logic [1:0] {SCAN_OUT, SCAN_START, SCAN_NAME, SCAN_REST} scan_mode_type;

   typedef struct packed {
      logic [7:0] text;
      logic       last;
   } doc_byte_type;

   typedef struct packed {
      logic       doc_ok;
      logic [2:0] kind;
   } verdict_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_text_byte = 8'h00;
   logic       req_end_of_document = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_document_valid;
   logic [2:0] rsp_error_kind;

   markup_tag_nesting_checker #(
      .STACK_DEPTH    (STACK_DEPTH),
      .MAX_NAME_BYTES (MAX_NAME_BYTES)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_text_byte       (req_text_byte),
      .req_end_of_document (req_end_of_document),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_document_valid  (rsp_document_valid),
      .rsp_error_kind      (rsp_error_kind)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Stimulus: bytes waiting to be sent, and the document being assembled
   doc_byte_type byte_backlog[$];
   logic [7:0]   doc_buf[$];
   doc_byte_type next_byte;
   int           docs_built = 0;

   // Progress counters, shared between processes
   int bytes_accepted   = 0;
   int verdicts_checked = 0;
   int stall_cycles     = 0;
   int fail_count       = 0;
   int hold_left        = 0;
   bit hold_used        = 1'b0;
   logic no_idle;

   assign no_idle = (bytes_accepted >= 400) && (bytes_accepted < 700);

   // Scanner shadow state
   scan_mode_type scan_mode;
   bit            in_closing;
   bit            close_bad;
   bit            last_was_slash;
   int            name_len;
   int            depth;
   logic [2:0]    first_err;
   logic [7:0]    name_mem [STACK_DEPTH*MAX_NAME_BYTES];
   int            len_mem [STACK_DEPTH];
   verdict_type   pending_verdicts[$];
   verdict_type   expected_verdict;
   int            kind_seen [7];

   function automatic void flag_error(input logic [2:0] kind);
      if (first_err == ERR_NONE) first_err = kind;
   endfunction

   function automatic void restart_scan();
      scan_mode      = SCAN_OUT;
      in_closing     = 1'b0;
      close_bad      = 1'b0;
      last_was_slash = 1'b0;
      name_len       = 0;
      depth          = 0;
      first_err      = ERR_NONE;
   endfunction

   // Opening tag: record the byte in the next slot. Closing tag: compare with the top entry.
   function automatic void take_name_char(input logic [7:0] ch);
      int top;
      if (name_len >= MAX_NAME_BYTES) begin
         flag_error(ERR_LONG);
         return;
      end
      top = depth - 1;
      if (!in_closing) begin
         if (depth < STACK_DEPTH) name_mem[depth*MAX_NAME_BYTES + name_len] = ch;
      end else if (depth == 0) begin
         close_bad = 1'b1;
      end else if (name_len >= len_mem[top] ||
                   name_mem[top*MAX_NAME_BYTES + name_len] != ch) begin
         close_bad = 1'b1;
      end
      name_len++;
   endfunction

   // Tag closed by '>': push, pop, or skip when it ended in "/>"
   function automatic void end_tag();
      scan_mode = SCAN_OUT;
      if (name_len == 0) begin
         flag_error(ERR_EMPTY);
      end else if (!last_was_slash && !in_closing) begin
         if (depth >= STACK_DEPTH) begin
            flag_error(ERR_OVERFLOW);
         end else begin
            len_mem[depth] = name_len;
            depth++;
         end
      end else if (!last_was_slash) begin
         if (depth == 0 || close_bad || name_len != len_mem[depth-1]) flag_error(ERR_MISMATCH);
         else depth--;
      end
   endfunction

   // One accepted byte; the last byte of a document queues its verdict
   function automatic void scan_byte(input logic [7:0] ch, input logic last);
      verdict_type v;
      case (scan_mode)
         SCAN_OUT: begin
            if (ch == CH_LT) begin
               scan_mode  = SCAN_START;
               in_closing = 1'b0;
               name_len   = 0;
               close_bad  = 1'b0;
            end
         end
         SCAN_START, SCAN_NAME: begin
            if (scan_mode == SCAN_START && !in_closing && ch == CH_SLASH) begin
               in_closing = 1'b1;
            end else if (ch == CH_GT) begin
               end_tag();
            end else if (ch == CH_SPACE || ch == CH_SLASH) begin
               scan_mode = SCAN_REST;
            end else begin
               take_name_char(ch);
               scan_mode = SCAN_NAME;
            end
         end
         default: begin
            if (ch == CH_GT) end_tag();
         end
      endcase
      last_was_slash = (ch == CH_SLASH);
      if (last) begin
         if (scan_mode != SCAN_OUT) flag_error(ERR_UNCLOSED);
         if (depth != 0) flag_error(ERR_OPEN);
         v.doc_ok = (first_err == ERR_NONE);
         v.kind   = first_err;
         pending_verdicts.push_back(v);
         kind_seen[first_err]++;
         restart_scan();
      end
   endfunction

   function automatic void report_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("ERROR at %0t: %s", $time, msg);
   endfunction

   // Bytes that steer the scanner, or anything at all
   function automatic logic [7:0] pick_special();
      case ($urandom_range(5))
         0: return CH_LT;
         1: return CH_GT;
         2: return CH_SLASH;
         3: return CH_SPACE;
         4: return 8'h61;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Close off the assembled document: its final byte carries the end mark
   task automatic commit_doc();
      doc_byte_type item;
      if (doc_buf.size() == 0) doc_buf.push_back(8'($urandom_range(255)));
      foreach (doc_buf[i]) begin
         item.text = doc_buf[i];
         item.last = (i == doc_buf.size() - 1);
         byte_backlog.push_back(item);
      end
      doc_buf.delete();
      docs_built++;
   endtask

   task automatic add_doc(input string s);
      for (int i = 0; i < s.len(); i++) doc_buf.push_back(s[i]);
      commit_doc();
   endtask

   // Mostly short letter names, some up to the limit, a few past it
   task automatic make_name(output logic [NAME_CAP*8-1:0] nm, output int len);
      int pick;
      logic [7:0] ch;
      pick = $urandom_range(99);
      if (pick < 75) len = $urandom_range(1, 3);
      else if (pick < 95) len = $urandom_range(4, MAX_NAME_BYTES);
      else len = $urandom_range(MAX_NAME_BYTES + 1, NAME_CAP);
      nm = '0;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(3) != 0) begin
            ch = 8'h61 + 8'($urandom_range(25));
         end else begin
            ch = 8'($urandom_range(255));
            // keep name terminators out of the name
            if (ch == CH_SPACE || ch == CH_SLASH || ch == CH_GT) ch = ch ^ 8'h01;
         end
         nm[i*8 +: 8] = ch;
      end
   endtask

   task automatic emit_tag(input logic [NAME_CAP*8-1:0] nm, input int len,
                           input bit closing, input bit self_close);
      doc_buf.push_back(CH_LT);
      if (closing) doc_buf.push_back(CH_SLASH);
      for (int i = 0; i < len; i++) doc_buf.push_back(nm[i*8 +: 8]);
      // optional attribute
      if ($urandom_range(3) == 0) begin
         doc_buf.push_back(CH_SPACE);
         doc_buf.push_back(8'h6B);
         doc_buf.push_back(8'h3D);
         doc_buf.push_back(8'h30 + 8'($urandom_range(9)));
      end
      if (self_close) begin
         if ($urandom_range(1) != 0) doc_buf.push_back(CH_SPACE);
         doc_buf.push_back(CH_SLASH);
      end
      doc_buf.push_back(CH_GT);
   endtask

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid           <= 1'b0;
         req_text_byte       <= 8'h00;
         req_end_of_document <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (byte_backlog.size() != 0 && (no_idle || $urandom_range(99) >= 29)) begin
            next_byte = byte_backlog.pop_front();
            req_valid           <= 1'b1;
            req_text_byte       <= next_byte.text;
            req_end_of_document <= next_byte.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Verdict receiver: random stalls plus one long hold to back up the request side
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         hold_used <= 1'b0;
      end else if (!hold_used && verdicts_checked >= HOLD_START) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_used <= 1'b1;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= no_idle || ($urandom_range(99) >= 29);
      end
   end

   // Monitor: predict on each accepted request, check each accepted verdict
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) scan_byte(req_text_byte, req_end_of_document);
         if (rsp_valid && rsp_ready) begin
            if (pending_verdicts.size() == 0) begin
               report_failure($sformatf("unexpected verdict: document_valid %0b error_kind %0d",
                                        rsp_document_valid, rsp_error_kind));
            end else begin
               expected_verdict = pending_verdicts.pop_front();
               if (rsp_document_valid !== expected_verdict.doc_ok)
                  report_failure($sformatf("document_valid expected %0b got %0b",
                                           expected_verdict.doc_ok, rsp_document_valid));
               if (rsp_error_kind !== expected_verdict.kind)
                  report_failure($sformatf("error_kind expected %0d got %0d",
                                           expected_verdict.kind, rsp_error_kind));
            end
            verdicts_checked <= verdicts_checked + 1;
         end
         bytes_accepted <= bytes_accepted + int'(req_valid && req_ready);
         stall_cycles   <= ((req_valid && req_ready) || (rsp_valid && rsp_ready)) ?
                           0 : stall_cycles + 1;
      end
   end

   initial begin : run
      int                    total_bytes;
      int                    random_start;
      int                    random_docs;
      int                    pick;
      int                    pos;
      int                    nm_len;
      bit                    timed_out;
      logic [7:0]            ch;
      logic [NAME_CAP*8-1:0] nm;
      logic [NAME_CAP*8-1:0] open_names[$];
      int                    open_lens[$];
      logic [7:0]            deep_names[$];

      restart_scan();
      foreach (kind_seen[k]) kind_seen[k] = 0;

      // Directed documents
      add_doc("<a></a>");
      add_doc("<a/>");
      add_doc("<a />");
      add_doc("</a/>");              // self-closing closing tag is skipped
      add_doc("<a k=1><b/>t</a>");
      add_doc("<>");                 // empty name
      add_doc("</ x>");              // empty closing name
      add_doc("</a>");               // close on an empty stack
      add_doc("<ab></a>");           // closing name is a prefix of the open one
      add_doc("<a></b>");
      add_doc("<a>");                // tag left open at the end
      add_doc("<a");                 // document ends inside a tag
      add_doc("<abcdefghijklmnopq/>"); // name one byte too long, even though self-closing
      add_doc("<>x</y>");            // later mismatch keeps the first error
      add_doc("x");
      // byte extremes as text and as name bytes
      doc_buf.push_back(8'h00);
      doc_buf.push_back(8'hFF);
      doc_buf.push_back(CH_LT);
      doc_buf.push_back(8'hFF);
      doc_buf.push_back(CH_GT);
      doc_buf.push_back(CH_LT);
      doc_buf.push_back(8'h00);
      doc_buf.push_back(CH_SLASH);
      doc_buf.push_back(CH_GT);
      doc_buf.push_back(CH_LT);
      doc_buf.push_back(CH_SLASH);
      doc_buf.push_back(8'hFF);
      doc_buf.push_back(CH_GT);
      commit_doc();

      // Random documents: mostly nested well-formed, some corrupted, some noise
      random_start = byte_backlog.size();
      random_docs  = 0;
      while (byte_backlog.size() - random_start < RANDOM_BYTES || random_docs < RANDOM_DOCS) begin
         pick = $urandom_range(99);
         if (random_docs == DEEP_DOC_INDEX) begin
            // fill the stack, overflow it by one, then unwind the stored entries
            for (int i = 0; i < STACK_DEPTH + 1; i++) begin
               ch = 8'h61 + 8'($urandom_range(25));
               deep_names.push_back(ch);
               doc_buf.push_back(CH_LT);
               doc_buf.push_back(ch);
               doc_buf.push_back(CH_GT);
            end
            void'(deep_names.pop_back());
            while (deep_names.size() != 0) begin
               doc_buf.push_back(CH_LT);
               doc_buf.push_back(CH_SLASH);
               doc_buf.push_back(deep_names.pop_back());
               doc_buf.push_back(CH_GT);
            end
         end else if (pick < 10) begin
            repeat ($urandom_range(1, 12)) doc_buf.push_back(pick_special());
         end else begin
            repeat ($urandom_range(1, 8)) begin
               case ($urandom_range(3))
                  0: begin
                     make_name(nm, nm_len);
                     emit_tag(nm, nm_len, 1'b0, 1'b0);
                     open_names.push_back(nm);
                     open_lens.push_back(nm_len);
                  end
                  1: begin
                     if (open_names.size() != 0)
                        emit_tag(open_names.pop_back(), open_lens.pop_back(), 1'b1, 1'b0);
                  end
                  2: begin
                     make_name(nm, nm_len);
                     emit_tag(nm, nm_len, $urandom_range(3) == 0, 1'b1);
                  end
                  default: begin
                     repeat ($urandom_range(1, 4)) begin
                        ch = 8'($urandom_range(255));
                        doc_buf.push_back((ch == CH_LT) ? CH_GT : ch);
                     end
                  end
               endcase
            end
            while (open_names.size() != 0)
               emit_tag(open_names.pop_back(), open_lens.pop_back(), 1'b1, 1'b0);
            // break some of them: truncate, overwrite, insert or drop a byte
            if (pick < 28) begin
               if (doc_buf.size() == 0) doc_buf.push_back(pick_special());
               pos = $urandom_range(doc_buf.size() - 1);
               case ($urandom_range(3))
                  0: begin
                     while (doc_buf.size() > pos + 1) void'(doc_buf.pop_back());
                  end
                  1: doc_buf[pos] = pick_special();
                  2: doc_buf.insert(pos, pick_special());
                  default: doc_buf.delete(pos);
               endcase
            end
         end
         commit_doc();
         random_docs++;
      end
      total_bytes = byte_backlog.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Run until every byte is in and every verdict is out, or nothing moves
      while (!(bytes_accepted == total_bytes && pending_verdicts.size() == 0) &&
             stall_cycles < STALL_LIMIT)
         @(negedge clock);
      timed_out = (stall_cycles >= STALL_LIMIT);
      if (!timed_out) repeat (TAIL_CYCLES) @(negedge clock);
      if (timed_out) $display("watchdog: nothing accepted for %0d cycles", STALL_LIMIT);
      if (pending_verdicts.size() != 0)
         report_failure($sformatf("%0d verdicts never arrived", pending_verdicts.size()));

      $display("run: %0d documents, %0d bytes, %0d verdicts checked, %0d failures",
               docs_built, total_bytes, verdicts_checked, fail_count);
      $display("verdicts: ok %0d, open bracket %0d, empty name %0d, mismatch %0d, %s",
               kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3],
               $sformatf("open tags %0d, long name %0d, overflow %0d",
                         kind_seen[4], kind_seen[5], kind_seen[6]));
      if (!timed_out && fail_count == 0)
         $display("markup_tag_nesting_checker_tb OK");
      else
         $display("markup_tag_nesting_checker_tb NOT OK");
      $finish;
   end

endmodule

[files.f]
src/mtnc_pkg.sv
src/mtnc_stack_mem.sv
src/mtnc_parser.sv
src/markup_tag_nesting_checker.sv
src/mtnc_checker.sv
bench/markup_tag_nesting_checker_tb.sv
